/* rtl/dfr_pkg.sv */
// shared types, constants and format helpers of the chunk deframer
`timescale 1ns / 1ps

package dfr_pkg;

  // framing constants
  localparam int unsigned CHUNK_SIZE = 512;
  localparam int unsigned HDR_LEN    = 9;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'(CHUNK_SIZE - HDR_LEN);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // special byte values
  localparam logic [7:0] NUL_BYTE  = 8'h00;
  localparam logic [7:0] FMT_T_LO  = 8'h74;  // 't'
  localparam logic [7:0] FMT_F_LO  = 8'h66;  // 'f'
  localparam logic [7:0] FMT_T_UP  = 8'h54;  // 'T'
  localparam logic [7:0] FMT_F_UP  = 8'h46;  // 'F'

  // front sequencer states
  typedef enum logic [1:0] {
    FR_ACCEPT,
    FR_CHECK,
    FR_DRAIN
  } dfr_state_t;

  // one result beat as it travels through the queue
  typedef struct packed {
    logic [7:0]         byte_val;
    logic               from_chunk;
    logic [15:0]        chunk_length;
    logic signed [31:0] sender_pid;
    logic               csv_format;
    logic               final_fragment;
    logic               last_of_run;
  } dfr_item_t;

  // queue handshake toward the front
  typedef struct packed {
    logic full;
  } dfr_qstat_t;

  function automatic logic fmt_ok(input logic [7:0] f);
    return (f == FMT_T_LO) || (f == FMT_F_LO) || (f == FMT_T_UP) || (f == FMT_F_UP);
  endfunction

  function automatic logic fmt_csv(input logic [7:0] f);
    return (f == FMT_T_UP) || (f == FMT_F_UP);
  endfunction

  function automatic logic fmt_final(input logic [7:0] f);
    return (f == FMT_T_LO) || (f == FMT_T_UP);
  endfunction

endpackage

/* rtl/dfr_front.sv */
// front end: takes input beats, tracks header window and payload, makes result beats
`timescale 1ns / 1ps

module dfr_front import dfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  dfr_qstat_t  qstat,
  output logic        push_valid,
  output dfr_item_t   push_item
);

  localparam int unsigned WIN_LAST = HDR_LEN - 1;

  dfr_state_t         state_r, state_nxt;
  logic [7:0]         win_r [HDR_LEN];
  logic [7:0]         win_nxt [HDR_LEN];
  logic [3:0]         fill_r, fill_nxt;
  logic [15:0]        payload_left_r, payload_left_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [31:0]        pid_r, pid_nxt;
  logic [7:0]         fmt_r, fmt_nxt;
  logic               stray_r, stray_nxt;
  logic [3:0]         drain_cnt_r, drain_cnt_nxt;
  logic               nul_found_r, nul_found_nxt;
  logic [15:0]        max_payload_r;

  logic               accept;
  logic [15:0]        hdr_len;
  logic [31:0]        hdr_pid;
  logic               hdr_ok;
  logic [3:0]         nul_pos;
  logic               nul_any;

  assign accept = in_tvalid && in_tready;

  // header fields straight from the window
  assign hdr_len = {win_r[3], win_r[2]};
  assign hdr_pid = {win_r[7], win_r[6], win_r[5], win_r[4]};
  assign hdr_ok  = (win_r[0] == NUL_BYTE) && (win_r[1] == NUL_BYTE) &&
                   (hdr_len != 16'd0) && (hdr_len <= max_payload_r) &&
                   (hdr_pid != 32'd0) && fmt_ok(win_r[WIN_LAST]);

  // first nul at window position 1 and up, position 8 when none
  always_comb begin
    nul_pos = 4'(WIN_LAST);
    nul_any = 1'b0;
    for (int i = WIN_LAST; i >= 1; i--) begin
      if (win_r[i] == NUL_BYTE) begin
        nul_pos = 4'(i);
        nul_any = 1'b1;
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= FR_ACCEPT;
      fill_r         <= '0;
      payload_left_r <= '0;
      len_r          <= '0;
      pid_r          <= '0;
      fmt_r          <= '0;
      stray_r        <= 1'b0;
      drain_cnt_r    <= '0;
      nul_found_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fill_r         <= fill_nxt;
      payload_left_r <= payload_left_nxt;
      len_r          <= len_nxt;
      pid_r          <= pid_nxt;
      fmt_r          <= fmt_nxt;
      stray_r        <= stray_nxt;
      drain_cnt_r    <= drain_cnt_nxt;
      nul_found_r    <= nul_found_nxt;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // next state and result beats
  always_comb begin
    state_nxt        = state_r;
    win_nxt          = win_r;
    fill_nxt         = fill_r;
    payload_left_nxt = payload_left_r;
    len_nxt          = len_r;
    pid_nxt          = pid_r;
    fmt_nxt          = fmt_r;
    stray_nxt        = stray_r;
    drain_cnt_nxt    = drain_cnt_r;
    nul_found_nxt    = nul_found_r;
    in_tready        = 1'b0;
    push_valid       = 1'b0;
    push_item        = '0;

    case (state_r)
      FR_ACCEPT: begin
        in_tready = !qstat.full;
        if (accept) begin
          if (payload_left_r != 16'd0) begin
            // chunk payload
            push_valid                = 1'b1;
            push_item.byte_val        = in_tdata;
            push_item.from_chunk      = 1'b1;
            push_item.chunk_length    = len_r;
            push_item.sender_pid      = pid_r;
            push_item.csv_format      = fmt_csv(fmt_r);
            push_item.final_fragment  = fmt_final(fmt_r);
            push_item.last_of_run     = (payload_left_r == 16'd1);
            payload_left_nxt          = payload_left_r - 16'd1;
          end else if (stray_r) begin
            // pending stray tail goes out, new byte waits
            push_valid            = 1'b1;
            push_item.byte_val    = win_r[0];
            push_item.last_of_run = (in_tdata == NUL_BYTE);
            win_nxt[0]            = in_tdata;
            fill_nxt              = 4'd1;
            if (in_tdata == NUL_BYTE) begin
              stray_nxt = 1'b0;
            end
          end else begin
            // collect header candidate
            win_nxt[fill_r] = in_tdata;
            fill_nxt        = fill_r + 4'd1;
            if (fill_r == 4'(WIN_LAST)) begin
              state_nxt = FR_CHECK;
            end
          end
        end
      end

      FR_CHECK: begin
        if (hdr_ok) begin
          len_nxt          = hdr_len;
          pid_nxt          = hdr_pid;
          fmt_nxt          = win_r[WIN_LAST];
          payload_left_nxt = hdr_len;
          fill_nxt         = '0;
          state_nxt        = FR_ACCEPT;
        end else begin
          drain_cnt_nxt = nul_pos;
          nul_found_nxt = nul_any;
          fill_nxt      = 4'(HDR_LEN) - nul_pos;
          state_nxt     = FR_DRAIN;
        end
      end

      FR_DRAIN: begin
        // one stray byte per beat, window slides down behind it
        if (!qstat.full) begin
          push_valid            = 1'b1;
          push_item.byte_val    = win_r[0];
          push_item.last_of_run = (drain_cnt_r == 4'd1) && nul_found_r;
          for (int i = 0; i < WIN_LAST; i++) begin
            win_nxt[i] = win_r[i + 1];
          end
          drain_cnt_nxt = drain_cnt_r - 4'd1;
          if (drain_cnt_r == 4'd1) begin
            stray_nxt = !nul_found_r;
            state_nxt = FR_ACCEPT;
          end
        end
      end

      default: begin
        state_nxt = FR_ACCEPT;
      end
    endcase
  end

  // window never overfills
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 4'(HDR_LEN))
    else $error("window fill out of range");

  // draining always has bytes left to send
  a_drain_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_DRAIN) |-> (drain_cnt_r != 4'd0))
    else $error("drain with empty count");

  // every payload beat makes exactly one result
  a_payload_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (payload_left_r != 16'd0)) |-> (push_valid && push_item.from_chunk))
    else $error("payload beat without result");

  // no push into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !qstat.full)
    else $error("push while queue full");

endmodule

/* rtl/dfr_queue.sv */
// short result queue between front and back
`timescale 1ns / 1ps

module dfr_queue import dfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  dfr_item_t  push_item,
  output dfr_qstat_t qstat,
  output logic       pop_valid,
  input  logic       pop_ready,
  output dfr_item_t  pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dfr_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign qstat.full = (count_r == CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !qstat.full;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/dfr_back.sv */
// back end: output register stage and stream packing of result beats
`timescale 1ns / 1ps

module dfr_back import dfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  dfr_item_t   pop_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic      valid_r, valid_nxt;
  dfr_item_t item_r;

  // load a new beat when the stage is empty or being taken
  assign pop_ready = !valid_r || out_tready;
  assign valid_nxt = pop_valid || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      item_r <= pop_item;
    end
  end

  // stream packing
  assign out_tvalid = valid_r;
  assign out_tdata  = {item_r.sender_pid, item_r.chunk_length, item_r.byte_val};
  assign out_tuser  = {item_r.final_fragment, item_r.csv_format, item_r.from_chunk};
  assign out_tlast  = item_r.last_of_run;

endmodule

/* rtl/log_pipe_chunk_deframer_core.sv */
// top level of the log pipe chunk deframer
// path: a result beat is registered in a queue entry, then in the output stage
// throughput: one payload, header or stray tail byte per cycle while the queue has
// room; the ninth header byte starts a check state, and a failed header then sends
// one to eight stray bytes from the window shift register, one per cycle with room
// reset: synchronous active-low rst_n empties window, queue and output stage
`timescale 1ns / 1ps

module log_pipe_chunk_deframer_core import dfr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // data_byte
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data, // max_payload
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // out_byte, chunk_length, sender_pid
  output logic [2:0]  out_tuser,   // from_chunk, csv_format, final_fragment
  output logic        out_tlast    // last_of_run
);

  dfr_qstat_t qstat;
  logic       push_valid;
  dfr_item_t  push_item;
  logic       pop_valid;
  logic       pop_ready;
  dfr_item_t  pop_item;

  // header tracking and classification
  dfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .qstat       (qstat),
    .push_valid  (push_valid),
    .push_item   (push_item)
  );

  // decoupling queue
  dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .qstat      (qstat),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // output stage
  dfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* test/deframer_checker.sv */
// checker for the chunk deframer: predicts output beats and compares them
`timescale 1ns / 1ps

module deframer_checker import dfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  // predictor state
  logic [7:0]  win [0:HDR_LEN-1];
  int          win_fill;
  logic [15:0] payload_left;
  logic [15:0] hdr_len;
  logic [31:0] hdr_pid;
  logic        hdr_csv;
  logic        hdr_final;
  logic        stray_run;
  logic [15:0] max_len;

  // beats predicted but not yet seen on the out channel
  dfr_item_t beats_due[$];

  function automatic void push_stray(input logic [7:0] b, input logic last);
    dfr_item_t r;
    r = '0;
    r.byte_val    = b;
    r.last_of_run = last;
    beats_due.push_back(r);
  endfunction

  // advance the predictor by one input byte
  function automatic void take_byte(input logic [7:0] b);
    dfr_item_t   r;
    logic [15:0] len;
    logic [31:0] pid;
    logic [7:0]  fmt;
    logic        fmt_good;
    int          nul_at;
    int          k;

    // payload phase
    if (payload_left != 0) begin
      r.byte_val       = b;
      r.from_chunk     = 1'b1;
      r.chunk_length   = hdr_len;
      r.sender_pid     = hdr_pid;
      r.csv_format     = hdr_csv;
      r.final_fragment = hdr_final;
      r.last_of_run    = (payload_left == 16'd1);
      beats_due.push_back(r);
      payload_left = payload_left - 16'd1;
      return;
    end

    // pending stray tail goes out once the next byte shows up
    if (stray_run) begin
      push_stray(win[0], b == NUL_BYTE);
      win[0]   = b;
      win_fill = 1;
      if (b == NUL_BYTE) stray_run = 1'b0;
      return;
    end

    // collect header candidate
    if (win_fill >= int'(HDR_LEN)) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill < int'(HDR_LEN)) return;

    len = {win[3], win[2]};
    pid = {win[7], win[6], win[5], win[4]};
    fmt = win[8];
    fmt_good = (fmt == FMT_T_LO) || (fmt == FMT_F_LO) || (fmt == FMT_T_UP) || (fmt == FMT_F_UP);

    if (win[0] == NUL_BYTE && win[1] == NUL_BYTE && len != 0 && len <= max_len &&
        pid != 0 && fmt_good) begin
      hdr_len      = len;
      hdr_pid      = pid;
      hdr_csv      = (fmt == FMT_T_UP) || (fmt == FMT_F_UP);
      hdr_final    = (fmt == FMT_T_LO) || (fmt == FMT_T_UP);
      payload_left = len;
      win_fill     = 0;
      return;
    end

    // bad header: look for a NUL to resync on
    nul_at = int'(HDR_LEN);
    for (k = int'(HDR_LEN) - 1; k >= 1; k--)
      if (win[k] == NUL_BYTE) nul_at = k;

    if (nul_at < int'(HDR_LEN)) begin
      for (k = 0; k < nul_at; k++)
        push_stray(win[k], k == nul_at - 1);
      for (k = 0; k < int'(HDR_LEN) - nul_at; k++)
        win[k] = win[k + nul_at];
      win_fill = int'(HDR_LEN) - nul_at;
    end else begin
      for (k = 0; k < int'(HDR_LEN) - 1; k++)
        push_stray(win[k], 1'b0);
      win[0]    = win[HDR_LEN-1];
      win_fill  = 1;
      stray_run = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // sample both channels and the config port at each edge
  always @(posedge clk) begin : watch
    dfr_item_t got;
    dfr_item_t want;
    if (!rst_n) begin
      fail_count   = 0;
      win_fill     = 0;
      payload_left = '0;
      hdr_len      = '0;
      hdr_pid      = '0;
      hdr_csv      = 1'b0;
      hdr_final    = 1'b0;
      stray_run    = 1'b0;
      max_len      = MAX_PAYLOAD_RST;
      beats_due.delete();
    end else begin
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (in_tvalid && in_tready) take_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got.byte_val       = out_tdata[7:0];
        got.chunk_length   = out_tdata[23:8];
        got.sender_pid     = out_tdata[55:24];
        got.from_chunk     = out_tuser[0];
        got.csv_format     = out_tuser[1];
        got.final_fragment = out_tuser[2];
        got.last_of_run    = out_tlast;
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = beats_due.pop_front();
          check_field("out_byte", 32'(want.byte_val), 32'(got.byte_val));
          check_field("from_chunk", 32'(want.from_chunk), 32'(got.from_chunk));
          check_field("chunk_length", 32'(want.chunk_length), 32'(got.chunk_length));
          check_field("sender_pid", 32'(want.sender_pid), 32'(got.sender_pid));
          check_field("csv_format", 32'(want.csv_format), 32'(got.csv_format));
          check_field("final_fragment", 32'(want.final_fragment),
                      32'(got.final_fragment));
          check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
      end
    end
    pending <= beats_due.size();
  end

endmodule

/* test/tb_top.sv */
// top of the deframer testbench: clock, reset, byte stimulus, sink stalls, verdict
`timescale 1ns / 1ps

module tb_top;
  import dfr_pkg::*;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {SINK_FREE, SINK_COIN, SINK_SLOW, SINK_COMB} sink_mode_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          bytes_sent  = 0;
  logic [15:0] cur_max     = MAX_PAYLOAD_RST;

  log_pipe_chunk_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  deframer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // sink side: a new stall pattern and run length are drawn whenever the current run ends
  initial begin : sink
    sink_mode_t mode;
    int         left;
    mode = SINK_FREE;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        SINK_FREE: out_tready <= 1'b1;
        SINK_COIN: out_tready <= 1'($urandom_range(0, 1));
        SINK_SLOW: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= (cycle_count % 5 != 2);
      endcase
    end
  end

  // send one byte; bursts of random length with random gaps in between
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 5);
      end
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic push_header(input logic [15:0] len, input logic [31:0] pid,
                             input logic [7:0] fmt);
    push_byte(NUL_BYTE);
    push_byte(NUL_BYTE);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    push_byte(pid[7:0]);
    push_byte(pid[15:8]);
    push_byte(pid[23:16]);
    push_byte(pid[31:24]);
    push_byte(fmt);
  endtask

  task automatic push_chunk(input logic [15:0] len, input logic [31:0] pid,
                            input logic [7:0] fmt);
    int i;
    push_header(len, pid, fmt);
    for (i = 0; i < int'(len); i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_fmt();
    case ($urandom_range(0, 3))
      0:       return FMT_T_LO;
      1:       return FMT_F_LO;
      2:       return FMT_T_UP;
      default: return FMT_F_UP;
    endcase
  endfunction

  // payload length: mostly short, now and then the limit when it is small
  function automatic logic [15:0] pick_len();
    int hi;
    if (cur_max == 0) return 16'($urandom_range(1, 6));
    if ($urandom_range(0, 15) == 0)
      return (cur_max <= 64) ? cur_max : 16'($urandom_range(13, 64));
    hi = (cur_max < 12) ? int'(cur_max) : 12;
    return 16'($urandom_range(1, hi));
  endfunction

  // wait until every predicted beat is out and the pipeline has gone quiet
  task automatic settle();
    do begin
      while (pending != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic write_cfg(input logic [15:0] v);
    in_tvalid <= 1'b0;
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_max = v;
  endtask

  // mix of good chunks, broken headers and raw noise
  task automatic random_traffic(input int n);
    int          stop_at;
    int          i;
    int          cnt;
    logic [15:0] len;
    logic [31:0] pid;
    logic [7:0]  fmt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          pid = 32'($urandom());
          if (pid == 0) pid = 32'd1;
          push_chunk(pick_len(), pid, pick_fmt());
        end
        6, 7: begin
          len = pick_len();
          pid = 32'($urandom());
          if (pid == 0) pid = 32'd7;
          fmt = pick_fmt();
          b0  = NUL_BYTE;
          b1  = NUL_BYTE;
          case ($urandom_range(0, 5))
            0: len = '0;
            1: len = (cur_max == 16'hFFFF) ? 16'h0 : cur_max + 16'd1;
            2: pid = '0;
            3: begin
              fmt = 8'($urandom_range(0, 255));
              if ((fmt == FMT_T_LO) || (fmt == FMT_F_LO) ||
                  (fmt == FMT_T_UP) || (fmt == FMT_F_UP)) fmt = fmt ^ 8'h01;
            end
            4: b1 = 8'($urandom_range(1, 255));
            default: b0 = 8'($urandom_range(1, 255));
          endcase
          push_byte(b0);
          push_byte(b1);
          push_byte(len[7:0]);
          push_byte(len[15:8]);
          push_byte(pid[7:0]);
          push_byte(pid[15:8]);
          push_byte(pid[23:16]);
          push_byte(pid[31:24]);
          push_byte(fmt);
          cnt = $urandom_range(0, 6);
          for (i = 0; i < cnt; i++) push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          cnt = $urandom_range(1, 14);
          for (i = 0; i < cnt; i++) begin
            b = ($urandom_range(0, 3) == 0) ? NUL_BYTE : 8'($urandom_range(1, 255));
            push_byte(b);
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte chunk at the extremes of pid and byte value, lower-case non-final
    push_header(16'd1, 32'h8000_0000, FMT_F_LO);
    push_byte(8'hFF);
    // two-byte csv chunk carrying a NUL and a high byte
    push_header(16'd2, 32'hFFFF_FFFF, FMT_F_UP);
    push_byte(NUL_BYTE);
    push_byte(8'h80);
    // nine bytes with no NUL start a stray run, then its tail and a NUL end it
    for (i = 0; i < 9; i++) push_byte(8'(8'h41 + i));
    push_byte(8'h7F);
    push_byte(NUL_BYTE);
    // header with zero pid fails and resyncs on a NUL inside the window
    push_byte(NUL_BYTE);
    push_byte(8'd1);
    for (i = 0; i < 5; i++) push_byte(NUL_BYTE);
    push_byte(FMT_T_LO);
    push_chunk(16'd3, 32'h1234_5678, FMT_T_UP);
    push_chunk(16'd1, 32'h0000_0001, FMT_T_LO);

    random_traffic(55);

    // tightest nonzero limit
    write_cfg(16'd1);
    random_traffic(35);

    // no length accepted: everything is stray
    write_cfg(16'd0);
    push_header(16'd1, 32'h0000_0042, FMT_T_UP);
    random_traffic(15);

    // limit of 65527: a chunk under it, then headers just past it and at the top of the range
    write_cfg(16'd65527);
    push_chunk(16'd20, 32'h7FFF_FFFF, FMT_F_UP);
    push_header(16'd65528, 32'h0000_0100, FMT_T_LO);
    push_header(16'hFFFF, 32'h0001_0000, FMT_F_LO);
    random_traffic(25);

    write_cfg(16'd1000);
    random_traffic(25);

    write_cfg(16'($urandom_range(2, 600)));
    random_traffic(25);

    in_tvalid <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/dfr_back.sv
rtl/log_pipe_chunk_deframer_core.sv
test/deframer_checker.sv
test/tb_top.sv
